[src/dma4_pkg.sv]
// ============================================================================
// dma4_pkg
// Shared types, constants and helper functions of the four-channel DMA
// controller.
// ============================================================================
package dma4_pkg;

    localparam int NUM_CHANNELS = 4;
    localparam logic [2:0] NO_CHANNEL = 3'd4;

    // Request modes.
    localparam logic [1:0] MODE_WRITE = 2'd0;
    localparam logic [1:0] MODE_READ  = 2'd1;
    localparam logic [1:0] MODE_EVENT = 2'd2;
    localparam logic [1:0] MODE_TICK  = 2'd3;

    // Event kinds.
    localparam logic [1:0] EV_HBLANK = 2'd0;
    localparam logic [1:0] EV_VBLANK = 2'd1;
    localparam logic [1:0] EV_FIFO_A = 2'd2;
    localparam logic [1:0] EV_FIFO_B = 2'd3;

    // Result kinds.
    localparam logic [1:0] KIND_READ = 2'd0;
    localparam logic [1:0] KIND_COPY = 2'd1;
    localparam logic [1:0] KIND_IDLE = 2'd2;

    // Timing modes.
    localparam logic [1:0] TM_NOW     = 2'd0;
    localparam logic [1:0] TM_VBLANK  = 2'd1;
    localparam logic [1:0] TM_HBLANK  = 2'd2;
    localparam logic [1:0] TM_SPECIAL = 2'd3;

    // Address step codes.
    localparam logic [1:0] STEP_INC    = 2'd0;
    localparam logic [1:0] STEP_DEC    = 2'd1;
    localparam logic [1:0] STEP_FIXED  = 2'd2;
    localparam logic [1:0] STEP_RELOAD = 2'd3;

    // Register offsets.
    localparam logic [3:0] OFF_CTL_LO = 4'd10;
    localparam logic [3:0] OFF_CTL_HI = 4'd11;

    localparam logic [31:0] FIFO_A_ADDR = 32'h040000A0;
    localparam logic [31:0] FIFO_B_ADDR = 32'h040000A4;

    // Burst counter width; covers bursts of up to eight copies.
    localparam int CNT_W = 3;

    typedef struct packed {
        logic [1:0] mode;
        logic [1:0] channel;
        logic [3:0] reg_offset;
        logic [7:0] write_byte;
        logic [1:0] event_kind;
    } req_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  read_byte;
        logic [31:0] src_address;
        logic [31:0] dst_address;
        logic        word_size;
        logic [1:0]  active_channel;
        logic [3:0]  irq_mask;
        logic        last;
    } rsp_t;

    // One group of results caused by a single request.
    typedef struct packed {
        logic [1:0]       kind;
        logic [7:0]       read_byte;
        logic [31:0]      src;
        logic [31:0]      dst;
        logic             word_size;
        logic [1:0]       channel;
        logic [3:0]       irq;
        logic [CNT_W-1:0] final_idx;
    } grp_t;

    function automatic logic [2:0] lowest_of(input logic [3:0] set);
        logic [2:0] r;
        r = NO_CHANNEL;
        for (int i = 3; i >= 0; i--)
        begin
            if (set[i])
            begin
                r = 3'(i);
            end
        end
        return r;
    endfunction

    function automatic logic [31:0] dst_mask(input logic [1:0] c);
        return (c == 2'd3) ? 32'h0FFFFFFF : 32'h07FFFFFF;
    endfunction

    function automatic logic [31:0] src_mask(input logic [1:0] c);
        return (c == 2'd0) ? 32'h07FFFFFF : 32'h0FFFFFFF;
    endfunction

    function automatic logic [15:0] len_mask(input logic [1:0] c);
        return (c == 2'd3) ? 16'hFFFF : 16'h3FFF;
    endfunction

    // Transfer length loaded from the count register; zero means maximum.
    function automatic logic [16:0] load_len(input logic [1:0] c, input logic [15:0] cnt);
        logic [15:0] n;
        n = cnt & len_mask(c);
        return (n == 16'd0) ? ({1'b0, len_mask(c)} + 17'd1) : {1'b0, n};
    endfunction

    // Signed address step for one unit.
    function automatic logic [31:0] addr_step(input logic ws, input logic [1:0] code);
        logic [31:0] amt;
        amt = ws ? 32'd4 : 32'd2;
        unique case (code)
            STEP_INC:    return amt;
            STEP_DEC:    return -amt;
            STEP_FIXED:  return 32'd0;
            STEP_RELOAD: return amt;
            default:     return amt;
        endcase
    endfunction

endpackage

[src/four_channel_dma_controller.sv]
// ============================================================================
// four_channel_dma_controller
// Four-channel DMA controller with byte-wide register access, blank and
// sound fifo triggers, and one copy unit (or one fifo burst) per tick.
// ============================================================================
// Latency: a request is decided in the cycle it is taken; its first result
// appears on the next cycle from the result register.
// Throughput: one request per cycle while the result buffer is free; a fifo burst
// or a result stall holds the request side while the result buffer plays it out.
// Reset: asynchronous, clears all channel state; no channel is current.
module four_channel_dma_controller
    import dma4_pkg::*;
#(
    parameter int FIFO_BURST = 4
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_stall,
    input  req_t req_data,
    output logic rsp_valid,
    input  logic rsp_stall,
    output rsp_t rsp_data
);

    logic [31:0] src_reg   [NUM_CHANNELS];
    logic [31:0] dst_reg   [NUM_CHANNELS];
    logic [15:0] cnt_reg   [NUM_CHANNELS];
    logic [10:0] ctl_reg   [NUM_CHANNELS];
    logic [31:0] wsrc_reg  [NUM_CHANNELS];
    logic [31:0] wdst_reg  [NUM_CHANNELS];
    logic [16:0] wcnt_reg  [NUM_CHANNELS];
    logic [7:0]  pend_reg  [NUM_CHANNELS];
    logic [31:0] src_next  [NUM_CHANNELS];
    logic [31:0] dst_next  [NUM_CHANNELS];
    logic [15:0] cnt_next  [NUM_CHANNELS];
    logic [10:0] ctl_next  [NUM_CHANNELS];
    logic [31:0] wsrc_next [NUM_CHANNELS];
    logic [31:0] wdst_next [NUM_CHANNELS];
    logic [16:0] wcnt_next [NUM_CHANNELS];
    logic [7:0]  pend_next [NUM_CHANNELS];
    logic [3:0]  hb_reg, hb_next;
    logic [3:0]  vb_reg, vb_next;
    logic [3:0]  run_reg, run_next;
    logic [2:0]  cur_reg, cur_next;
    logic        pre_reg, pre_next;

    logic accept;
    logic buf_free;
    logic load;
    grp_t grp;

    assign req_stall = !buf_free;
    assign accept    = req_valid && !req_stall;

    // Request decode and next channel state.
    always_comb
    begin
        logic [1:0]  c;
        logic [10:0] ctl;
        logic [1:0]  tm;
        logic        was_on;
        logic        ws;
        logic [31:0] addr;
        logic [16:0] wc;

        src_next  = src_reg;
        dst_next  = dst_reg;
        cnt_next  = cnt_reg;
        ctl_next  = ctl_reg;
        wsrc_next = wsrc_reg;
        wdst_next = wdst_reg;
        wcnt_next = wcnt_reg;
        pend_next = pend_reg;
        hb_next   = hb_reg;
        vb_next   = vb_reg;
        run_next  = run_reg;
        cur_next  = cur_reg;
        pre_next  = pre_reg;
        load      = 1'b0;
        grp       = '0;
        c         = req_data.channel;
        ctl       = ctl_reg[req_data.channel];
        tm        = 2'd0;
        was_on    = 1'b0;
        ws        = 1'b0;
        addr      = 32'd0;
        wc        = 17'd0;

        if (accept)
        begin
            unique case (req_data.mode)
                MODE_WRITE:
                begin
                    if (req_data.reg_offset < 4'd4)
                    begin
                        src_next[c][8*req_data.reg_offset[1:0] +: 8] = req_data.write_byte;
                    end
                    else if (req_data.reg_offset < 4'd8)
                    begin
                        dst_next[c][8*req_data.reg_offset[1:0] +: 8] = req_data.write_byte;
                    end
                    else if (req_data.reg_offset < 4'd10)
                    begin
                        cnt_next[c][8*req_data.reg_offset[0] +: 8] = req_data.write_byte;
                    end
                    else if (req_data.reg_offset == OFF_CTL_LO)
                    begin
                        ctl_next[c][1:0] = req_data.write_byte[6:5];
                        ctl_next[c][2]   = req_data.write_byte[7];
                    end
                    else if (req_data.reg_offset == OFF_CTL_HI)
                    begin
                        was_on = ctl[10];
                        ctl[3]   = req_data.write_byte[0];
                        ctl[4]   = req_data.write_byte[2];
                        ctl[6:5] = req_data.write_byte[5:4];
                        ctl[7]   = req_data.write_byte[1];
                        ctl[8]   = req_data.write_byte[3];
                        ctl[9]   = req_data.write_byte[6];
                        ctl[10]  = req_data.write_byte[7];
                        ctl_next[c] = ctl;
                        tm = ctl[6:5];
                        hb_next[c] = 1'b0;
                        vb_next[c] = 1'b0;
                        if (ctl[10])
                        begin
                            if (tm == TM_HBLANK)
                            begin
                                hb_next[c] = 1'b1;
                            end
                            if (tm == TM_VBLANK)
                            begin
                                vb_next[c] = 1'b1;
                            end
                            if (!was_on)
                            begin
                                pend_next[c] = 8'd0;
                                wdst_next[c] = dst_reg[c] & dst_mask(c);
                                wsrc_next[c] = src_reg[c] & src_mask(c);
                                wcnt_next[c] = load_len(c, cnt_reg[c]);
                                if (tm == TM_NOW)
                                begin
                                    if (run_next == 4'd0)
                                    begin
                                        cur_next = {1'b0, c};
                                    end
                                    else if ({1'b0, c} < cur_next)
                                    begin
                                        cur_next = {1'b0, c};
                                        pre_next = 1'b1;
                                    end
                                    run_next[c] = 1'b1;
                                end
                            end
                        end
                        else if (run_reg[c])
                        begin
                            run_next[c] = 1'b0;
                            if (cur_reg == {1'b0, c})
                            begin
                                cur_next = lowest_of(run_next);
                            end
                        end
                    end
                end

                MODE_READ:
                begin
                    load = 1'b1;
                    grp.kind = KIND_READ;
                    if (req_data.reg_offset == OFF_CTL_LO)
                    begin
                        grp.read_byte = {ctl[2], ctl[1:0], 5'd0};
                    end
                    else if (req_data.reg_offset == OFF_CTL_HI)
                    begin
                        grp.read_byte = {ctl[10], ctl[9], ctl[6:5], ctl[8], ctl[4],
                                         ctl[7], ctl[3]};
                    end
                end

                MODE_EVENT:
                begin
                    if (req_data.event_kind == EV_HBLANK || req_data.event_kind == EV_VBLANK)
                    begin
                        // Start every armed channel, lowest first.
                        for (int i = 0; i < NUM_CHANNELS; i++)
                        begin
                            if ((req_data.event_kind == EV_HBLANK) ? hb_reg[i] : vb_reg[i])
                            begin
                                if (run_next == 4'd0)
                                begin
                                    cur_next = 3'(i);
                                end
                                else if (3'(i) < cur_next)
                                begin
                                    cur_next = 3'(i);
                                    pre_next = 1'b1;
                                end
                                run_next[i] = 1'b1;
                            end
                        end
                    end
                    else
                    begin
                        addr = (req_data.event_kind == EV_FIFO_A) ? FIFO_A_ADDR : FIFO_B_ADDR;
                        // Only channels one and two serve the sound fifos.
                        for (int i = 1; i <= 2; i++)
                        begin
                            if (ctl_reg[i][10] && ctl_reg[i][6:5] == TM_SPECIAL
                                && dst_reg[i] == addr)
                            begin
                                if (pend_reg[i] != 8'd255)
                                begin
                                    pend_next[i] = pend_reg[i] + 8'd1;
                                end
                                if (run_next == 4'd0)
                                begin
                                    cur_next = 3'(i);
                                end
                                else if (3'(i) < cur_next)
                                begin
                                    cur_next = 3'(i);
                                    pre_next = 1'b1;
                                end
                                run_next[i] = 1'b1;
                            end
                        end
                    end
                end

                MODE_TICK:
                begin
                    load = 1'b1;
                    grp.kind = KIND_IDLE;
                    if (cur_reg != NO_CHANNEL)
                    begin
                        c   = cur_reg[1:0];
                        ctl = ctl_reg[c];
                        grp.channel = c;
                        if (ctl[6:5] == TM_SPECIAL && (c == 2'd1 || c == 2'd2))
                        begin
                            // Sound fifo burst of word copies.
                            if (pend_reg[c] != 8'd0)
                            begin
                                pend_next[c] = pend_reg[c] - 8'd1;
                            end
                            if (pend_next[c] == 8'd0)
                            begin
                                run_next[c] = 1'b0;
                            end
                            grp.kind      = KIND_COPY;
                            grp.word_size = 1'b1;
                            grp.src       = wsrc_reg[c] & ~32'd3;
                            grp.dst       = wdst_reg[c] & ~32'd3;
                            grp.irq       = ctl[9] ? (4'd1 << c) : 4'd0;
                            grp.final_idx = CNT_W'(FIFO_BURST - 1);
                            wsrc_next[c]  = wsrc_reg[c] + 32'(4 * FIFO_BURST);
                            cur_next      = lowest_of(run_next);
                        end
                        else if (pre_reg)
                        begin
                            // First tick after a pre-emption is spent idle.
                            pre_next = 1'b0;
                        end
                        else
                        begin
                            wc = wcnt_reg[c];
                            if (wc != 17'd0)
                            begin
                                ws = ctl[4];
                                grp.kind      = KIND_COPY;
                                grp.word_size = ws;
                                grp.src = wsrc_reg[c] & (ws ? ~32'd3 : ~32'd1);
                                grp.dst = wdst_reg[c] & (ws ? ~32'd3 : ~32'd1);
                                wsrc_next[c] = wsrc_reg[c] + addr_step(ws, ctl[3:2]);
                                wdst_next[c] = wdst_reg[c] + addr_step(ws, ctl[1:0]);
                                wc = wc - 17'd1;
                                wcnt_next[c] = wc;
                            end
                            if (wc == 17'd0)
                            begin
                                // Transfer complete.
                                grp.irq = ctl[9] ? (4'd1 << c) : 4'd0;
                                if (ctl[7])
                                begin
                                    wcnt_next[c] = load_len(c, cnt_reg[c]);
                                    if (ctl[1:0] == STEP_RELOAD)
                                    begin
                                        wdst_next[c] = dst_reg[c] & dst_mask(c);
                                    end
                                    if (ctl[6:5] != TM_NOW)
                                    begin
                                        run_next[c] = 1'b0;
                                    end
                                end
                                else
                                begin
                                    ctl_next[c][10] = 1'b0;
                                    run_next[c] = 1'b0;
                                    hb_next[c]  = 1'b0;
                                    vb_next[c]  = 1'b0;
                                end
                                cur_next = lowest_of(run_next);
                            end
                        end
                    end
                end

                default:
                begin
                end
            endcase
        end
    end

    // Channel state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_CHANNELS; i++)
            begin
                src_reg[i]  <= '0;
                dst_reg[i]  <= '0;
                cnt_reg[i]  <= '0;
                ctl_reg[i]  <= '0;
                wsrc_reg[i] <= '0;
                wdst_reg[i] <= '0;
                wcnt_reg[i] <= '0;
                pend_reg[i] <= '0;
            end
            hb_reg  <= '0;
            vb_reg  <= '0;
            run_reg <= '0;
            cur_reg <= NO_CHANNEL;
            pre_reg <= 1'b0;
        end
        else
        begin
            src_reg  <= src_next;
            dst_reg  <= dst_next;
            cnt_reg  <= cnt_next;
            ctl_reg  <= ctl_next;
            wsrc_reg <= wsrc_next;
            wdst_reg <= wdst_next;
            wcnt_reg <= wcnt_next;
            pend_reg <= pend_next;
            hb_reg   <= hb_next;
            vb_reg   <= vb_next;
            run_reg  <= run_next;
            cur_reg  <= cur_next;
            pre_reg  <= pre_next;
        end
    end

    // Result buffer.
    dma4_result_buf u_result_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (load),
        .grp       (grp),
        .free      (buf_free),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp_data  (rsp_data)
    );

endmodule

[src/dma4_result_buf.sv]
// ============================================================================
// dma4_result_buf
// Holds one result group, plays it out one result per cycle while rsp_stall
// is low; a burst group steps the source address by one word per result.
// ============================================================================
module dma4_result_buf
    import dma4_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic load,
    input  grp_t grp,
    output logic free,
    output logic rsp_valid,
    input  logic rsp_stall,
    output rsp_t rsp_data
);

    logic             busy_reg;
    logic [CNT_W-1:0] idx_reg;
    grp_t             grp_reg;
    logic             is_last;
    logic             done;

    assign is_last = (idx_reg == grp_reg.final_idx);
    assign done    = busy_reg && !rsp_stall && is_last;
    assign free    = !busy_reg || done;

    // Group control and payload.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            idx_reg  <= '0;
        end
        else if (load)
        begin
            busy_reg <= 1'b1;
            idx_reg  <= '0;
        end
        else if (busy_reg && !rsp_stall)
        begin
            if (is_last)
            begin
                busy_reg <= 1'b0;
            end
            else
            begin
                idx_reg <= idx_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            grp_reg <= grp;
        end
    end

    // Only the final result carries the interrupt bits.
    assign rsp_valid               = busy_reg;
    assign rsp_data.kind           = grp_reg.kind;
    assign rsp_data.read_byte      = grp_reg.read_byte;
    assign rsp_data.src_address    = grp_reg.src + {27'd0, idx_reg, 2'b00};
    assign rsp_data.dst_address    = grp_reg.dst;
    assign rsp_data.word_size      = grp_reg.word_size;
    assign rsp_data.active_channel = grp_reg.channel;
    assign rsp_data.irq_mask       = is_last ? grp_reg.irq : 4'd0;
    assign rsp_data.last           = is_last;

endmodule
